/* rtl/core/vcr_pkg.sv */
// shared constants and types of the video chunk reassembler
package vcr_pkg;

	// default parameter values
	localparam int CHUNK_BYTES_DEF   = 25;
	localparam int MAX_CHUNKS_DEF    = 2048;
	localparam int MAX_FRAME_DIM_DEF = 128;

	// fixed field widths
	localparam int DIM_W       = 8;
	localparam int FRAME_NUM_W = 16;
	localparam int CHUNK_IDX_W = 16;
	localparam int ADDR_W      = 16;
	localparam int WORD_W      = 64;
	localparam int BYTE_W      = 8;
	localparam int COUNT_OUT_W = 12;

	// frame geometry
	localparam int BYTES_PER_PIXEL = 3;
	localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;

	// stored chunk image: three words and one tail byte, byte 0 in the low bits
	localparam int STORED_BYTES = 25;
	localparam int STORE_W      = 3 * WORD_W + BYTE_W;
	localparam int SEL_W        = $clog2(STORED_BYTES);

	// received-map generation tag
	localparam int EPOCH_W = 8;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// memory access controls
	typedef struct packed {
		logic rd_en;
		logic store_we;
		logic tag_we;
	} mem_ctrl_t;

endpackage

/* rtl/core/vcr_recip_div.sv */
// unsigned division by a constant through a reciprocal multiply
module vcr_recip_div #(
	parameter int IN_W    = 16,
	parameter int DIVISOR = vcr_pkg::CHUNK_BYTES_DEF
) (
	input  logic [IN_W-1:0] dividend,
	output logic [IN_W-1:0] quotient
);

	localparam int LD = $clog2(DIVISOR);
	localparam int SH = IN_W + LD;
	localparam longint unsigned RECIP = ((64'd1 << SH) + DIVISOR - 1) / DIVISOR;
	localparam int MW = IN_W + 2;
	localparam int PW = IN_W + MW;

	logic [MW-1:0] recip;
	logic [PW-1:0] prod;

	assign recip    = MW'(RECIP);
	// exact for every dividend below 2**IN_W since the rounding error stays under 2**LD
	assign prod     = PW'(dividend) * PW'(recip);
	assign quotient = IN_W'(prod >> SH);

endmodule

/* rtl/core/vcr_geom.sv */
// frame geometry registers and chunk total computation
module vcr_geom #(
	parameter int CHUNK_BYTES   = vcr_pkg::CHUNK_BYTES_DEF,
	parameter int MAX_CHUNKS    = vcr_pkg::MAX_CHUNKS_DEF,
	parameter int MAX_FRAME_DIM = vcr_pkg::MAX_FRAME_DIM_DEF,
	localparam int SIZE_W = $clog2(MAX_FRAME_DIM * MAX_FRAME_DIM * vcr_pkg::BYTES_PER_PIXEL + 1),
	localparam int CNT_W  = $clog2(MAX_CHUNKS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vcr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vcr_pkg::DIM_W-1:0]       cfg_data,
	output logic [SIZE_W-1:0]               geo_size,
	output logic [CNT_W-1:0]                geo_chunks
);

	localparam int CDIM_W = $clog2(MAX_FRAME_DIM + 1);
	localparam int PROD_W = 2 * CDIM_W;
	localparam int XW     = SIZE_W + 1;

	logic [vcr_pkg::DIM_W-1:0] width_q, height_q;
	logic [CDIM_W-1:0]         width_c, height_c;
	logic [PROD_W-1:0]         area_q;
	logic [SIZE_W-1:0]         size_raw;
	logic [XW-1:0]             div_in, div_quot;
	logic                      sat;
	logic [SIZE_W-1:0]         size_q;
	logic [CNT_W-1:0]          chunks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= vcr_pkg::DIM_RESET;
			height_q <= vcr_pkg::DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				vcr_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data;
				vcr_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// oversized dimensions count as the limit
	assign width_c  = (32'(width_q) > 32'(MAX_FRAME_DIM)) ? CDIM_W'(MAX_FRAME_DIM)
	                                                      : CDIM_W'(width_q);
	assign height_c = (32'(height_q) > 32'(MAX_FRAME_DIM)) ? CDIM_W'(MAX_FRAME_DIM)
	                                                       : CDIM_W'(height_q);

	// pixel count, then bytes and ceil chunk count
	assign size_raw = SIZE_W'(area_q) * SIZE_W'(vcr_pkg::BYTES_PER_PIXEL);
	assign div_in   = XW'(size_raw) + XW'(CHUNK_BYTES - 1);

	vcr_recip_div #(
		.IN_W    (XW),
		.DIVISOR (CHUNK_BYTES)
	) u_ceil_div (
		.dividend (div_in),
		.quotient (div_quot)
	);

	assign sat = 64'(div_quot) > 64'(MAX_CHUNKS);

	always_ff @(posedge clk) begin
		area_q   <= PROD_W'(width_c) * PROD_W'(height_c);
		chunks_q <= sat ? CNT_W'(MAX_CHUNKS) : CNT_W'(div_quot);
		size_q   <= sat ? SIZE_W'(MAX_CHUNKS * CHUNK_BYTES) : size_raw;
	end

	assign geo_size   = size_q;
	assign geo_chunks = chunks_q;

endmodule

/* rtl/core/vcr_chunk_mem.sv */
// chunk data memory and received-tag memory, registered read
module vcr_chunk_mem #(
	parameter int MAX_CHUNKS = vcr_pkg::MAX_CHUNKS_DEF,
	localparam int CIDX_W = $clog2(MAX_CHUNKS)
) (
	input  logic                           clk,
	input  vcr_pkg::mem_ctrl_t             ctrl,
	input  logic [CIDX_W-1:0]              rd_addr,
	input  logic [CIDX_W-1:0]              wr_addr,
	input  logic [vcr_pkg::STORE_W-1:0]    wr_store,
	input  logic [vcr_pkg::EPOCH_W-1:0]    wr_tag,
	output logic [vcr_pkg::STORE_W-1:0]    rd_store,
	output logic [vcr_pkg::EPOCH_W-1:0]    rd_tag
);

	logic [vcr_pkg::STORE_W-1:0] store_mem [MAX_CHUNKS];
	logic [vcr_pkg::EPOCH_W-1:0] tag_mem   [MAX_CHUNKS];

	always_ff @(posedge clk) begin
		if (ctrl.store_we) begin
			store_mem[wr_addr] <= wr_store;
		end
		if (ctrl.rd_en) begin
			rd_store <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.tag_we) begin
			tag_mem[wr_addr] <= wr_tag;
		end
		if (ctrl.rd_en) begin
			rd_tag <= tag_mem[rd_addr];
		end
	end

endmodule

/* rtl/core/video_chunk_reassembler.sv */
// video chunk reassembler top level: item sequencer, frame state and output register
//
// input channel (in_valid / in_stall): one item is either a chunk packet
// (req_type 0) or a read of one frame byte (req_type 1). output channel
// (out_valid / out_stall): exactly one result item per input item, in order.
// configuration channel (cfg_valid / cfg_ready): cfg_ready is always high;
// index 0 writes frame_width, index 1 frame_height, other indexes are ignored.
// a new geometry takes effect at the next frame open.
//
// each item passes three steps: register and split the read address, read
// the chunk and tag memories, then update and load the result register. a
// new item is taken in the update step of the last one, as its result is
// loaded, so the block takes no new item before the last reaches that step.
// the divide step, the memory read and the update step run in turn.
//
// after reset the tag memory is swept to zero, one entry per cycle, over all
// MAX_CHUNKS entries with in_stall high. the received map is kept as a tag per
// chunk against a frame generation; once the generation has reached 255 the
// next frame open wraps it and repeats that sweep before the packet is handled.
// while out_stall holds the result, the finished item waits in its update
// step and in_stall stays high; nothing is lost or repeated.
module video_chunk_reassembler #(
	parameter int CHUNK_BYTES   = vcr_pkg::CHUNK_BYTES_DEF,
	parameter int MAX_CHUNKS    = vcr_pkg::MAX_CHUNKS_DEF,
	parameter int MAX_FRAME_DIM = vcr_pkg::MAX_FRAME_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [vcr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vcr_pkg::DIM_W-1:0]         cfg_data,
	// input items
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic                              is_video_packet,
	input  logic [vcr_pkg::FRAME_NUM_W-1:0]   packet_frame_number,
	input  logic [vcr_pkg::CHUNK_IDX_W-1:0]   chunk_index,
	input  logic [vcr_pkg::WORD_W-1:0]        payload_bytes_0_7,
	input  logic [vcr_pkg::WORD_W-1:0]        payload_bytes_8_15,
	input  logic [vcr_pkg::WORD_W-1:0]        payload_bytes_16_23,
	input  logic [vcr_pkg::BYTE_W-1:0]        payload_byte_24,
	input  logic [vcr_pkg::ADDR_W-1:0]        read_address,
	// result items
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              frame_ready,
	output logic [vcr_pkg::BYTE_W-1:0]        read_byte,
	output logic [vcr_pkg::COUNT_OUT_W-1:0]   chunks_received
);

	localparam int CIDX_W  = $clog2(MAX_CHUNKS);
	localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
	localparam int SIZE_W  = $clog2(MAX_FRAME_DIM * MAX_FRAME_DIM * vcr_pkg::BYTES_PER_PIXEL + 1);
	localparam int POS_W   = $clog2(CHUNK_BYTES + 1);
	localparam int IDX_W   = vcr_pkg::CHUNK_IDX_W;
	localparam int AW      = vcr_pkg::ADDR_W;
	localparam int NUM_W   = vcr_pkg::FRAME_NUM_W;
	localparam int EPW     = vcr_pkg::EPOCH_W;
	localparam int SW      = vcr_pkg::STORE_W;
	localparam int SELW    = vcr_pkg::SEL_W;
	localparam int BW      = vcr_pkg::BYTE_W;
	localparam int OCNT_W  = vcr_pkg::COUNT_OUT_W;
	localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int ACMP_W  = (SIZE_W > AW) ? SIZE_W : AW;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIV    = 3'd1;
	localparam logic [2:0] ST_LOOKUP = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_CLEAR  = 3'd4;

	logic [2:0]          state_q;
	logic                resume_q;
	logic [CIDX_W-1:0]   clr_addr_q;

	// item held through its three steps
	logic                item_req_q;
	logic                item_video_q;
	logic [NUM_W-1:0]    item_num_q;
	logic [IDX_W-1:0]    item_chunk_q;
	logic [AW-1:0]       item_addr_q;
	logic [SW-1:0]       item_data_q;
	logic [AW-1:0]       item_quot_q;
	logic [POS_W-1:0]    item_pos_q;

	// open frame state
	logic                frame_open_q;
	logic [NUM_W-1:0]    open_num_q;
	logic [EPW-1:0]      epoch_q;
	logic [SIZE_W-1:0]   lat_size_q;
	logic [CNT_W-1:0]    lat_chunks_q;
	logic [CNT_W-1:0]    count_q;

	// result register
	logic                out_valid_q;
	logic                frame_ready_q;
	logic [BW-1:0]       read_byte_q;
	logic [OCNT_W-1:0]   count_out_q;

	logic                accept;
	logic                out_free;
	logic                open_now;
	logic                need_clear;
	logic                clr_last;
	logic [IDX_W-1:0]    look_chunk;
	logic                pkt_in_range;
	logic                is_new;
	logic                rd_hit;
	logic [SELW-1:0]     byte_sel;
	logic [BW-1:0]       sel_byte;
	logic [CNT_W-1:0]    count_nx;
	logic [AW-1:0]       div_quot;
	logic [SIZE_W-1:0]   geo_size;
	logic [CNT_W-1:0]    geo_chunks;

	vcr_pkg::mem_ctrl_t  mem_ctrl;
	logic [CIDX_W-1:0]   mem_wr_addr;
	logic [EPW-1:0]      mem_wr_tag;
	logic [SW-1:0]       mem_rd_store;
	logic [EPW-1:0]      mem_rd_tag;

	// geometry follows the config registers through the registered area, then registered size and total
	vcr_geom #(
		.CHUNK_BYTES   (CHUNK_BYTES),
		.MAX_CHUNKS    (MAX_CHUNKS),
		.MAX_FRAME_DIM (MAX_FRAME_DIM)
	) u_geom (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.geo_size   (geo_size),
		.geo_chunks (geo_chunks)
	);

	// read address split into chunk number and byte position
	vcr_recip_div #(
		.IN_W    (AW),
		.DIVISOR (CHUNK_BYTES)
	) u_addr_div (
		.dividend (item_addr_q),
		.quotient (div_quot)
	);

	vcr_chunk_mem #(
		.MAX_CHUNKS (MAX_CHUNKS)
	) u_mem (
		.clk      (clk),
		.ctrl     (mem_ctrl),
		.rd_addr  (look_chunk[CIDX_W-1:0]),
		.wr_addr  (mem_wr_addr),
		.wr_store (item_data_q),
		.wr_tag   (mem_wr_tag),
		.rd_store (mem_rd_store),
		.rd_tag   (mem_rd_tag)
	);

	assign cfg_ready = 1'b1;

	// handshakes
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_IDLE) || ((state_q == ST_UPDATE) && out_free));
	assign accept   = in_valid && !in_stall;

	// frame open decision, and a generation wrap that needs a sweep first
	assign open_now   = !item_req_q && item_video_q &&
	                    (!frame_open_q || (item_num_q != open_num_q));
	assign need_clear = open_now && (epoch_q == {EPW{1'b1}});
	assign clr_last   = clr_addr_q == CIDX_W'(MAX_CHUNKS - 1);

	assign look_chunk = item_req_q ? item_quot_q : item_chunk_q;

	// update step, with the frame state already switched by an open
	assign pkt_in_range = !item_req_q && item_video_q &&
	                      (CMP_W'(item_chunk_q) < CMP_W'(lat_chunks_q));
	assign is_new       = mem_rd_tag != epoch_q;
	assign count_nx     = (pkt_in_range && is_new) ? count_q + 1'b1 : count_q;

	// a read hits only a chunk received under the current generation
	assign rd_hit = item_req_q && frame_open_q &&
	                (ACMP_W'(item_addr_q) < ACMP_W'(lat_size_q)) &&
	                (CMP_W'(item_quot_q) < CMP_W'(lat_chunks_q)) &&
	                (mem_rd_tag == epoch_q) &&
	                (32'(item_pos_q) < 32'(vcr_pkg::STORED_BYTES));
	assign byte_sel = SELW'(item_pos_q);
	assign sel_byte = mem_rd_store[byte_sel * BW +: BW];

	// memory controls
	assign mem_ctrl.rd_en    = (state_q == ST_LOOKUP) && !need_clear;
	assign mem_ctrl.store_we = (state_q == ST_UPDATE) && out_free && pkt_in_range;
	assign mem_ctrl.tag_we   = mem_ctrl.store_we || (state_q == ST_CLEAR);
	assign mem_wr_addr       = (state_q == ST_CLEAR) ? clr_addr_q : item_chunk_q[CIDX_W-1:0];
	assign mem_wr_tag        = (state_q == ST_CLEAR) ? '0 : epoch_q;

	// sequencer and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			resume_q     <= 1'b0;
			clr_addr_q   <= '0;
			frame_open_q <= 1'b0;
			open_num_q   <= '0;
			epoch_q      <= '0;
			lat_size_q   <= '0;
			lat_chunks_q <= '0;
			count_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: begin
					if (need_clear) begin
						// sweep the tags, then come back to open the frame
						state_q    <= ST_CLEAR;
						resume_q   <= 1'b1;
						clr_addr_q <= '0;
					end else begin
						if (open_now) begin
							frame_open_q <= 1'b1;
							open_num_q   <= item_num_q;
							epoch_q      <= epoch_q + 1'b1;
							lat_size_q   <= geo_size;
							lat_chunks_q <= geo_chunks;
							count_q      <= '0;
						end
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						count_q <= count_nx;
						state_q <= accept ? ST_DIV : ST_IDLE;
					end
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_last) begin
						epoch_q  <= '0;
						resume_q <= 1'b0;
						state_q  <= resume_q ? ST_LOOKUP : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_req_q   <= req_type;
			item_video_q <= is_video_packet;
			item_num_q   <= packet_frame_number;
			item_chunk_q <= chunk_index;
			item_addr_q  <= read_address;
			item_data_q  <= {payload_byte_24, payload_bytes_16_23,
			                 payload_bytes_8_15, payload_bytes_0_7};
		end
		if (state_q == ST_DIV) begin
			item_quot_q <= div_quot;
		end
		if (state_q == ST_LOOKUP) begin
			item_pos_q <= POS_W'(item_addr_q - AW'(item_quot_q * CHUNK_BYTES));
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_UPDATE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_UPDATE) && out_free) begin
			frame_ready_q <= frame_open_q && (count_nx == lat_chunks_q);
			read_byte_q   <= rd_hit ? sel_byte : '0;
			count_out_q   <= OCNT_W'(count_nx);
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_ready     = frame_ready_q;
	assign read_byte       = read_byte_q;
	assign chunks_received = count_out_q;

	// distinct chunk count never passes the frame's chunk total
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frame_open_q |-> (count_q <= lat_chunks_q))
		else $error("received count above chunk total");

	// no tag write in the same cycle as a lookup read
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_ctrl.rd_en && mem_ctrl.tag_we))
		else $error("tag memory read and write in the same cycle");

	// the tag sweep ends with the generation back at zero
	a_sweep_epoch: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CLEAR) && clr_last) |=> (epoch_q == '0))
		else $error("generation not reset after tag sweep");

	// an open frame never uses the generation that the sweep leaves in memory
	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_open_q && (state_q == ST_UPDATE)) |-> (epoch_q != '0))
		else $error("open frame on the swept generation");

endmodule
